/* design/atp_pkg.sv */
// Shared types and constants for the accelerometer tilt pitch block.
package atp_pkg;

  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned DEG_W     = 9;
  localparam int unsigned ACC_W     = 27;  // signed Q9.16 degrees plus headroom
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned ATAN_W    = 22;
  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned VEC_GUARD = 19;  // vector bits beyond the stage shift

  localparam logic signed [DEG_W-1:0] DEG_MAX = 9'sd180;
  localparam logic signed [DEG_W-1:0] DEG_MIN = -9'sd180;
  localparam logic signed [DEG_W-1:0] DEG_90  = 9'sd90;
  localparam logic signed [DEG_W-1:0] DEG_M90 = -9'sd90;
  localparam logic signed [DEG_W-1:0] DEG_0   = 9'sd0;

  localparam logic signed [ACC_W-1:0] ACC_P180 = 27'sd11796480;
  localparam logic signed [ACC_W-1:0] ACC_M180 = -27'sd11796480;

  // atan(2^-i) in degrees, Q.16, rounded to nearest
  localparam logic [ATAN_W-1:0] ATAN_DEG_Q16 [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  // Fields that ride alongside the CORDIC vector
  typedef struct packed {
    logic signed [AXIS_W-1:0] x_axis;
    logic signed [AXIS_W-1:0] y_axis;
    logic signed [AXIS_W-1:0] z_axis;
    logic                     spec;      // answer known without iterating
    logic signed [DEG_W-1:0]  spec_deg;
  } side_t;

endpackage

/* design/atp_in_if.sv */
// Input channel: one accelerometer sample as six raw bytes.
interface atp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] x_low_byte;
  logic [7:0] x_high_byte;
  logic [7:0] y_low_byte;
  logic [7:0] y_high_byte;
  logic [7:0] z_low_byte;
  logic [7:0] z_high_byte;

  modport source (
    output valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
           z_low_byte, z_high_byte,
    input  ready
  );
  modport sink (
    input  valid, x_low_byte, x_high_byte, y_low_byte, y_high_byte,
           z_low_byte, z_high_byte,
    output ready
  );
endinterface

/* design/atp_out_if.sv */
// Output channel: axis values and pitch angle.
interface atp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_axis;
  logic signed [15:0] y_axis;
  logic signed [15:0] z_axis;
  logic signed [8:0]  pitch_degrees;

  modport source (
    output valid, x_axis, y_axis, z_axis, pitch_degrees,
    input  ready
  );
  modport sink (
    input  valid, x_axis, y_axis, z_axis, pitch_degrees,
    output ready
  );
endinterface

/* design/atp_pre.sv */
// Quadrant pre-rotation and detection of the on-axis cases.
module atp_pre #(
  parameter int unsigned STAGES = 16,
  parameter int unsigned VEC_W  = 35
) (
  input  logic signed [atp_pkg::AXIS_W-1:0] x_i,
  input  logic signed [atp_pkg::AXIS_W-1:0] y_i,
  input  logic signed [atp_pkg::AXIS_W-1:0] z_i,
  output logic signed [VEC_W-1:0]           vx_o,
  output logic signed [VEC_W-1:0]           vy_o,
  output logic signed [atp_pkg::ACC_W-1:0]  acc_o,
  output atp_pkg::side_t                    side_o
);
  import atp_pkg::*;

  localparam int unsigned EXT_W = VEC_W - (AXIS_W + 1) - STAGES;

  logic signed [AXIS_W:0] x_e, z_e, vx_s, vy_s;
  logic                   z_neg, x_zero, z_zero;

  always_comb begin
    x_e    = {x_i[AXIS_W-1], x_i};
    z_e    = {z_i[AXIS_W-1], z_i};
    z_neg  = z_i[AXIS_W-1];
    x_zero = (x_i == '0);
    z_zero = (z_i == '0);

    // left half-plane: turn by 180 degrees and start from +-180
    if (z_neg) begin
      vx_s  = -z_e;
      vy_s  = -x_e;
      acc_o = x_i[AXIS_W-1] ? ACC_M180 : ACC_P180;
    end else begin
      vx_s  = z_e;
      vy_s  = x_e;
      acc_o = '0;
    end

    vx_o = $signed({{EXT_W{vx_s[AXIS_W]}}, vx_s, {STAGES{1'b0}}});
    vy_o = $signed({{EXT_W{vy_s[AXIS_W]}}, vy_s, {STAGES{1'b0}}});

    side_o.x_axis = x_i;
    side_o.y_axis = y_i;
    side_o.z_axis = z_i;
    side_o.spec   = x_zero || z_zero;
    if (x_zero) begin
      side_o.spec_deg = z_neg ? DEG_MAX : DEG_0;
    end else begin
      side_o.spec_deg = x_i[AXIS_W-1] ? DEG_M90 : DEG_90;
    end
  end

endmodule

/* design/atp_cell.sv */
// One CORDIC vectoring cell: a single micro-rotation and its pipeline register.
module atp_cell #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned VEC_W = 35
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  logic signed [VEC_W-1:0]           vx_i,
  input  logic signed [VEC_W-1:0]           vy_i,
  input  logic signed [atp_pkg::ACC_W-1:0]  acc_i,
  input  atp_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic signed [VEC_W-1:0]           vx_o,
  output logic signed [VEC_W-1:0]           vy_o,
  output logic signed [atp_pkg::ACC_W-1:0]  acc_o,
  output atp_pkg::side_t                    side_o
);
  import atp_pkg::*;

  localparam logic signed [ACC_W-1:0] STEP =
    $signed({{(ACC_W-ATAN_W){1'b0}}, ATAN_DEG_Q16[STAGE]});

  logic                      valid_q;
  logic signed [VEC_W-1:0]   vx_d, vx_q, vy_d, vy_q, dx, dy;
  logic signed [ACC_W-1:0]   acc_d, acc_q;
  side_t                     side_q;

  always_comb begin
    dx = vy_i >>> STAGE;
    dy = vx_i >>> STAGE;
    if (!vy_i[VEC_W-1]) begin
      vx_d  = vx_i + dx;
      vy_d  = vy_i - dy;
      acc_d = acc_i + STEP;
    end else begin
      vx_d  = vx_i - dx;
      vy_d  = vy_i + dy;
      acc_d = acc_i - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

/* design/accel_tilt_pitch_degrees.sv */
// Accelerometer tilt pitch: byte assembly, CORDIC atan2 cell chain, output register.
// Each beat passes through the CORDIC_STAGES cell registers and then the output register.
// Throughput: one beat per cycle; the chain of CORDIC_STAGES cells advances as one.
// A stalled output holds the whole chain; ready is low only while the output waits.
// Reset clears the valid bits of the cells and the output register; data is not reset.
module accel_tilt_pitch_degrees #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  atp_in_if.sink   in_i,
  atp_out_if.source out_o
);
  import atp_pkg::*;

  localparam int unsigned N     = CORDIC_STAGES;
  localparam int unsigned VEC_W = CORDIC_STAGES + VEC_GUARD;

  logic                     adv;
  logic                     valid_c [N+1];
  logic signed [VEC_W-1:0]  vx_c    [N+1];
  logic signed [VEC_W-1:0]  vy_c    [N+1];
  logic signed [ACC_W-1:0]  acc_c   [N+1];
  side_t                    side_c  [N+1];

  logic signed [AXIS_W-1:0] x_raw, y_raw, z_raw;

  assign x_raw = $signed({in_i.x_high_byte, in_i.x_low_byte});
  assign y_raw = $signed({in_i.y_high_byte, in_i.y_low_byte});
  assign z_raw = $signed({in_i.z_high_byte, in_i.z_low_byte});

  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;
  assign valid_c[0] = in_i.valid;

  atp_pre #(
    .STAGES (N),
    .VEC_W  (VEC_W)
  ) u_pre (
    .x_i    (x_raw),
    .y_i    (y_raw),
    .z_i    (z_raw),
    .vx_o   (vx_c[0]),
    .vy_o   (vy_c[0]),
    .acc_o  (acc_c[0]),
    .side_o (side_c[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    atp_cell #(
      .STAGE (g),
      .VEC_W (VEC_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid_c[g]),
      .vx_i    (vx_c[g]),
      .vy_i    (vy_c[g]),
      .acc_i   (acc_c[g]),
      .side_i  (side_c[g]),
      .valid_o (valid_c[g+1]),
      .vx_o    (vx_c[g+1]),
      .vy_o    (vy_c[g+1]),
      .acc_o   (acc_c[g+1]),
      .side_o  (side_c[g+1])
    );
  end

  // Q9.16 to whole degrees, truncated toward zero, then clamped; on-axis cases take spec_deg
  localparam int unsigned WHOLE_W = ACC_W - FRAC_W;

  logic signed [ACC_W-1:0]   acc_last, acc_neg, acc_mag;
  logic        [WHOLE_W-1:0] whole;
  logic signed [WHOLE_W:0]   deg_w;
  logic signed [DEG_W-1:0]   pitch_d, pitch_q;
  logic                      out_valid_q;
  side_t                     out_side_q;

  always_comb begin
    acc_last = acc_c[N];
    acc_neg  = -acc_last;
    acc_mag  = acc_last[ACC_W-1] ? acc_neg : acc_last;
    whole    = acc_mag[ACC_W-1:FRAC_W];
    deg_w    = acc_last[ACC_W-1] ? -$signed({1'b0, whole}) : $signed({1'b0, whole});
    if (side_c[N].spec) begin
      pitch_d = side_c[N].spec_deg;
    end else if (deg_w > (WHOLE_W+1)'(DEG_MAX)) begin
      pitch_d = DEG_MAX;
    end else if (deg_w < (WHOLE_W+1)'(DEG_MIN)) begin
      pitch_d = DEG_MIN;
    end else begin
      pitch_d = deg_w[DEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= valid_c[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_side_q <= side_c[N];
      pitch_q    <= pitch_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.x_axis        = out_side_q.x_axis;
  assign out_o.y_axis        = out_side_q.y_axis;
  assign out_o.z_axis        = out_side_q.z_axis;
  assign out_o.pitch_degrees = pitch_q;

endmodule
